// ----- design/brrc_pkg.sv -----
// Package for the resource request check block: sizes, codes and types.
// No dependencies.
package brrc_pkg;
  localparam int unsigned MaxProcs     = 8;
  localparam int unsigned MaxResources = 8;
  localparam int unsigned AmountWidth  = 16;
  localparam int unsigned WorkWidth    = AmountWidth + 4;
  localparam int unsigned ProcW        = $clog2(MaxProcs);
  localparam int unsigned ResW         = $clog2(MaxResources);
  localparam int unsigned EntW         = ProcW + ResW;

  localparam logic [1:0] KindAvail   = 2'd0;
  localparam logic [1:0] KindLoad    = 2'd1;
  localparam logic [1:0] KindRequest = 2'd2;
  localparam logic [1:0] KindUnused  = 2'd3;

  localparam logic [2:0] StGranted = 3'd0;
  localparam logic [2:0] StExceeds = 3'd1;
  localparam logic [2:0] StWait    = 3'd2;
  localparam logic [2:0] StUnsafe  = 3'd3;
  localparam logic [2:0] StBadProc = 3'd4;

  localparam logic CfgProcs = 1'b0;
  localparam logic CfgRes   = 1'b1;

  typedef logic [AmountWidth-1:0] amount_t;
  typedef logic [WorkWidth-1:0]   work_t;
endpackage

// ----- design/bankers_resource_request_check_core.sv -----
// Top level of the resource request check: tables, sequencer, shared
// compare/add unit. Depends on brrc_pkg.
//
// Load items are taken in idle. A check walks one (entry, resource) pair at a
// time through the shared compare/add unit: need check, availability check,
// tentative update, seeding of the work vector, then passes of the safety
// scan until a pass finishes no entry, then the rollback if unsafe, then one
// result item per finished entry, or a single status item.
// One item at a time; not ready while checking or sending results. Reset:
// asynchronous, active low; all tables read as zero, registers at their reset
// values.
module bankers_resource_request_check_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: process_index[2:0], resource_index[5:3], amount[21:6],
  // allocated_amount[37:22], zeros[39:38]
  input  logic [39:0] s_axis_tdata,
  input  logic        s_axis_tlast,  // last_element
  input  logic [1:0]  s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: seq_process[2:0], seq_valid[3], zeros[7:4]
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast,  // last_result
  output logic [2:0]  m_axis_tuser,  // status
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [3:0]  cfg_wdata_i
);
  localparam int unsigned P = brrc_pkg::MaxProcs;
  localparam int unsigned R = brrc_pkg::MaxResources;
  localparam int unsigned PW = brrc_pkg::ProcW;
  localparam int unsigned RW = brrc_pkg::ResW;
  localparam int unsigned EW = brrc_pkg::EntW;
  localparam int unsigned WW = brrc_pkg::WorkWidth;
  localparam logic [WW-1:0] WorkMax = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK_NEED, S_CHK_AVAIL, S_APPLY, S_SCAN_INIT, S_SCAN_CMP,
    S_SCAN_ADD, S_ROLLBACK, S_OUT
  } state_e;

  logic [PW-1:0] in_proc;
  logic [RW-1:0] in_res;
  brrc_pkg::amount_t in_amt, in_alloc;
  assign in_proc  = s_axis_tdata[PW-1:0];
  assign in_res   = s_axis_tdata[RW+2:3];
  assign in_amt   = s_axis_tdata[21:6];
  assign in_alloc = s_axis_tdata[37:22];

  state_e state_q;
  logic [3:0] np_q, nr_q;
  logic [PW:0] np;
  logic [RW:0] nr;
  assign np = (np_q > 4'(P)) ? (PW+1)'(P) : np_q[PW:0];
  assign nr = (nr_q > 4'(R)) ? (RW+1)'(R) : nr_q[RW:0];

  brrc_pkg::amount_t avail_q [R];
  brrc_pkg::amount_t req_q   [R];
  brrc_pkg::work_t   work_q  [R];
  brrc_pkg::amount_t alloc_mem [P*R];
  brrc_pkg::amount_t need_mem  [P*R];
  logic [P*R-1:0] alloc_vld_q, need_vld_q;
  logic [P-1:0] fin_q;
  logic [PW-1:0] seq_q [P];

  logic [PW-1:0] proc_q, cur_q;   // requesting entry, scanned entry
  logic [RW:0]   r_q;             // resource counter
  logic          fits_q, prog_q;
  logic [PW:0]   cnt_q, oidx_q;
  logic [2:0]    status_q;

  // shared table read, registered
  logic [EW-1:0] rd_addr;
  brrc_pkg::amount_t alloc_rd_q, need_rd_q;
  logic [RW-1:0] ridx;
  assign ridx = r_q[RW-1:0];

  logic in_acc, out_acc;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // shared unit: one compare and one saturating add on widened operands
  logic [WW-1:0] op_a, op_b;
  logic [WW:0]   sum;
  logic          gt;
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_q)
      S_CHK_NEED:  begin op_a = WW'(req_q[ridx]); op_b = WW'(need_rd_q); end
      S_CHK_AVAIL: begin op_a = WW'(req_q[ridx]); op_b = WW'(avail_q[ridx]); end
      S_SCAN_CMP:  begin op_a = WW'(need_rd_q);   op_b = work_q[ridx]; end
      S_SCAN_ADD:  begin op_a = work_q[ridx];     op_b = WW'(alloc_rd_q); end
      default: ;
    endcase
  end
  assign gt  = op_a > op_b;
  assign sum = {1'b0, op_a} + {1'b0, op_b};

  // address of the next pair read; the read data is registered, so each
  // pass step reads ahead and compares in the next cycle.
  logic rd_phase_q;
  assign rd_addr = {(state_q == S_SCAN_CMP || state_q == S_SCAN_ADD) ? cur_q : proc_q, ridx};

  always_ff @(posedge clk_i) begin
    alloc_rd_q <= alloc_vld_q[rd_addr] ? alloc_mem[rd_addr] : '0;
    need_rd_q  <= need_vld_q[rd_addr]  ? need_mem[rd_addr]  : '0;
  end

  // memory writes: loads and grant/rollback updates
  logic          mem_we;
  logic [EW-1:0] mem_wa;
  brrc_pkg::amount_t mem_alloc_wd, mem_need_wd;
  always_comb begin
    mem_we = 1'b0;
    mem_wa = {in_proc, in_res};
    mem_alloc_wd = in_alloc;
    mem_need_wd  = (in_amt > in_alloc) ? in_amt - in_alloc : '0;
    if (in_acc && s_axis_tuser == brrc_pkg::KindLoad) begin
      mem_we = 1'b1;
    end else if ((state_q == S_APPLY || state_q == S_ROLLBACK) && rd_phase_q) begin
      mem_we = 1'b1;
      mem_wa = {proc_q, ridx};
      if (state_q == S_APPLY) begin
        mem_alloc_wd = alloc_rd_q + req_q[ridx];
        mem_need_wd  = need_rd_q - req_q[ridx];
      end else begin
        mem_alloc_wd = alloc_rd_q - req_q[ridx];
        mem_need_wd  = need_rd_q + req_q[ridx];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      alloc_mem[mem_wa] <= mem_alloc_wd;
      need_mem[mem_wa]  <= mem_need_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < R; i++) req_q[i] <= '0;
    end else if (in_acc && s_axis_tuser == brrc_pkg::KindRequest) begin
      req_q[in_res] <= in_amt;
    end else if (state_q == S_OUT && oidx_q == '0) begin
      for (int i = 0; i < R; i++) req_q[i] <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      np_q        <= '0;
      nr_q        <= 4'd1;
      alloc_vld_q <= '0;
      need_vld_q  <= '0;
      fin_q       <= '0;
      for (int i = 0; i < R; i++) begin
        avail_q[i] <= '0;
        work_q[i]  <= '0;
      end
      for (int i = 0; i < P; i++) seq_q[i] <= '0;
      proc_q <= '0; cur_q <= '0; r_q <= '0; fits_q <= 1'b0; prog_q <= 1'b0;
      cnt_q <= '0; oidx_q <= '0; status_q <= '0; rd_phase_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == brrc_pkg::CfgProcs) np_q <= cfg_wdata_i;
        else                                 nr_q <= cfg_wdata_i;
      end
      if (mem_we) begin
        alloc_vld_q[mem_wa] <= 1'b1;
        need_vld_q[mem_wa]  <= 1'b1;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser == brrc_pkg::KindAvail) begin
              avail_q[in_res] <= in_amt;
            end else if (s_axis_tuser == brrc_pkg::KindRequest && s_axis_tlast) begin
              proc_q <= in_proc;
              r_q <= '0;
              rd_phase_q <= 1'b0;
              oidx_q <= '0;
              if ((PW+1)'(in_proc) >= np) begin
                status_q <= brrc_pkg::StBadProc;
                cnt_q <= '0;
                state_q <= S_OUT;
              end else begin
                state_q <= S_CHK_NEED;
              end
            end
          end
        end
        // each step reads in its read phase, then compares
        S_CHK_NEED: begin
          if (r_q >= nr) begin
            r_q <= '0; rd_phase_q <= 1'b0; state_q <= S_CHK_AVAIL;
          end else if (!rd_phase_q) begin
            rd_phase_q <= 1'b1;
          end else begin
            rd_phase_q <= 1'b0;
            if (gt) begin
              status_q <= brrc_pkg::StExceeds; cnt_q <= '0; state_q <= S_OUT;
            end else r_q <= r_q + 1'b1;
          end
        end
        S_CHK_AVAIL: begin
          if (r_q >= nr) begin
            r_q <= '0; state_q <= S_APPLY;
          end else if (gt) begin
            status_q <= brrc_pkg::StWait; cnt_q <= '0; state_q <= S_OUT;
          end else r_q <= r_q + 1'b1;
        end
        S_APPLY, S_ROLLBACK: begin
          if (r_q >= nr) begin
            r_q <= '0;
            rd_phase_q <= 1'b0;
            if (state_q == S_APPLY) state_q <= S_SCAN_INIT;
            else begin
              status_q <= brrc_pkg::StUnsafe; cnt_q <= '0; state_q <= S_OUT;
            end
          end else if (!rd_phase_q) begin
            rd_phase_q <= 1'b1;
          end else begin
            rd_phase_q <= 1'b0;
            if (state_q == S_APPLY) avail_q[ridx] <= avail_q[ridx] - req_q[ridx];
            else                    avail_q[ridx] <= avail_q[ridx] + req_q[ridx];
            r_q <= r_q + 1'b1;
          end
        end
        S_SCAN_INIT: begin
          for (int i = 0; i < R; i++)
            work_q[i] <= ((RW+1)'(i) < nr) ? WW'(avail_q[i]) : '0;
          fin_q <= '0; cnt_q <= '0; cur_q <= '0; r_q <= '0;
          fits_q <= 1'b1; prog_q <= 1'b0; rd_phase_q <= 1'b0;
          state_q <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          if (fin_q[cur_q] || r_q >= nr) begin
            r_q <= '0;
            rd_phase_q <= 1'b0;
            if (!fin_q[cur_q] && fits_q) begin
              state_q <= S_SCAN_ADD;
            end else begin
              fits_q <= 1'b1;
              if ((PW+1)'(cur_q) + 1'b1 >= np) begin
                cur_q <= '0;
                prog_q <= 1'b0;
                if (!prog_q) state_q <= (cnt_q >= np) ? S_OUT : S_ROLLBACK;
              end else cur_q <= cur_q + 1'b1;
              if (!prog_q && (PW+1)'(cur_q) + 1'b1 >= np) begin
                status_q <= brrc_pkg::StGranted; oidx_q <= '0;
              end
            end
          end else if (!rd_phase_q) begin
            rd_phase_q <= 1'b1;
          end else begin
            rd_phase_q <= 1'b0;
            if (gt) fits_q <= 1'b0;
            r_q <= r_q + 1'b1;
          end
        end
        // hold the entry; the compare state sees it finished and advances
        S_SCAN_ADD: begin
          if (r_q >= nr) begin
            r_q <= '0;
            rd_phase_q <= 1'b0;
            fin_q[cur_q] <= 1'b1;
            seq_q[cnt_q[PW-1:0]] <= cur_q;
            cnt_q <= cnt_q + 1'b1;
            prog_q <= 1'b1;
            fits_q <= 1'b1;
            state_q <= S_SCAN_CMP;
          end else if (!rd_phase_q) begin
            rd_phase_q <= 1'b1;
          end else begin
            rd_phase_q <= 1'b0;
            work_q[ridx] <= sum[WW] ? WorkMax : sum[WW-1:0];
            r_q <= r_q + 1'b1;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            if (m_axis_tlast) state_q <= S_IDLE;
            else oidx_q <= oidx_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Pass end wraps with prog cleared; a pass that finished something
  // restarts from entry zero because cur wraps and prog is reset there.
  logic granted;
  assign granted = (status_q == brrc_pkg::StGranted);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tuser  = status_q;
  assign m_axis_tlast  = granted ? (oidx_q + 1'b1 >= cnt_q) : 1'b1;
  assign m_axis_tdata  = {4'b0, granted, granted ? seq_q[oidx_q[PW-1:0]] : {PW{1'b0}}};
endmodule

// ----- test/tb.sv -----
// Testbench for bankers_resource_request_check_core: directed and random items
// checked against an in-bench predictor of the request check. Depends on brrc_pkg.
module tb;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic [2:0]  m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [3:0]  cfg_wdata_i = '0;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] seq_proc;
    logic       seq_ok;
    logic       last;
  } verdict_t;

  // Predictor state: own copy of tables and registers
  int unsigned n_procs, n_res;
  longint unsigned avail[brrc_pkg::MaxResources];
  longint unsigned alloc_tab[brrc_pkg::MaxProcs][brrc_pkg::MaxResources];
  longint unsigned need_tab[brrc_pkg::MaxProcs][brrc_pkg::MaxResources];
  longint unsigned req_buf[brrc_pkg::MaxResources];
  verdict_t verdicts_due[$];
  int mismatches = 0;
  bit timed_out = 1'b0;

  bankers_resource_request_check_core dut (.*);

  always #2 clk_i = ~clk_i;

  function automatic void push_verdict(logic [2:0] st, int sp, bit ok, bit lst);
    verdict_t v;
    v.status = st; v.seq_proc = sp[2:0]; v.seq_ok = ok; v.last = lst;
    verdicts_due = {verdicts_due, v};
  endfunction

  // Banker's check on the buffered request of entry p
  function automatic void predict_check(int unsigned p);
    int unsigned np, nr, cnt;
    longint unsigned work[brrc_pkg::MaxResources];
    longint unsigned wmax;
    bit done[brrc_pkg::MaxProcs];
    int order[brrc_pkg::MaxProcs];
    bit moved, fits, bad;
    np = (n_procs > brrc_pkg::MaxProcs) ? brrc_pkg::MaxProcs : n_procs;
    nr = (n_res > brrc_pkg::MaxResources) ? brrc_pkg::MaxResources : n_res;
    wmax = (64'd1 << brrc_pkg::WorkWidth) - 1;
    cnt = 0;
    if (p >= np) begin
      push_verdict(brrc_pkg::StBadProc, 0, 0, 1);
      return;
    end
    bad = 0;
    for (int j = 0; j < nr; j++) if (req_buf[j] > need_tab[p][j]) bad = 1;
    if (bad) begin
      push_verdict(brrc_pkg::StExceeds, 0, 0, 1);
      return;
    end
    for (int j = 0; j < nr; j++) if (req_buf[j] > avail[j]) bad = 1;
    if (bad) begin
      push_verdict(brrc_pkg::StWait, 0, 0, 1);
      return;
    end
    for (int j = 0; j < nr; j++) begin
      avail[j] -= req_buf[j];
      alloc_tab[p][j] = (alloc_tab[p][j] + req_buf[j]) & 64'hFFFF;
      need_tab[p][j] -= req_buf[j];
    end
    for (int j = 0; j < brrc_pkg::MaxResources; j++) work[j] = (j < nr) ? avail[j] : 0;
    for (int i = 0; i < brrc_pkg::MaxProcs; i++) done[i] = 0;
    do begin
      moved = 0;
      for (int i = 0; i < np; i++) begin
        if (done[i]) continue;
        fits = 1;
        for (int j = 0; j < nr; j++) if (need_tab[i][j] > work[j]) fits = 0;
        if (!fits) continue;
        for (int j = 0; j < nr; j++) begin
          work[j] += alloc_tab[i][j];
          if (work[j] > wmax) work[j] = wmax;
        end
        done[i] = 1;
        order[cnt++] = i;
        moved = 1;
      end
    end while (moved);
    if (cnt < np) begin
      // roll the tentative grant back
      for (int j = 0; j < nr; j++) begin
        avail[j] += req_buf[j];
        alloc_tab[p][j] = (alloc_tab[p][j] - req_buf[j]) & 64'hFFFF;
        need_tab[p][j] += req_buf[j];
      end
      push_verdict(brrc_pkg::StUnsafe, 0, 0, 1);
      return;
    end
    for (int k = 0; k < cnt; k++)
      push_verdict(brrc_pkg::StGranted, order[k], 1, k + 1 == cnt);
  endfunction

  function automatic void predict_item(logic [1:0] kind, int p, int r, int amt,
                                       int alc, bit lst);
    case (kind)
      brrc_pkg::KindAvail: avail[r] = amt;
      brrc_pkg::KindLoad: begin
        alloc_tab[p][r] = alc;
        need_tab[p][r] = (amt > alc) ? amt - alc : 0;
      end
      brrc_pkg::KindRequest: begin
        req_buf[r] = amt;
        if (lst) begin
          predict_check(p);
          for (int j = 0; j < brrc_pkg::MaxResources; j++) req_buf[j] = 0;
        end
      end
      default: ;
    endcase
  endfunction

  // Send one item after a random gap; predict it on acceptance.
  // Hold tvalid high across back-to-back items; drop it only for a gap.
  task automatic send_item(logic [1:0] kind, int p, int r, int amt, int alc, bit lst);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tlast  <= lst;
    s_axis_tdata  <= {2'b00, alc[15:0], amt[15:0], r[2:0], p[2:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_item(kind, p, r, amt, alc, lst);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (900) @(posedge clk_i);
  endtask

  task automatic set_reg(logic idx, int val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val[3:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == brrc_pkg::CfgProcs) n_procs = val; else n_res = val;
  endtask

  // Receiver: random stalls, compare each result against the oldest verdict
  always @(posedge clk_i) begin
    verdict_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[3], m_axis_tlast};
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = verdicts_due.pop_front();
        if (got !== want || m_axis_tdata[7:4] !== 4'b0) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk_i) begin
    int stall_n;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      stall_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
      stall_left <= (stall_n > 0) ? stall_n - 1 : 0;
      m_axis_tready <= (stall_n == 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Load a random consistent state and fire a few requests
  task automatic random_scenario(int np, int nr, int reqs);
    int mx;
    mx = ($urandom_range(0, 1) != 0) ? 20 : 65535;
    for (int j = 0; j < nr; j++)
      send_item(brrc_pkg::KindAvail, $urandom_range(0, 7), j, $urandom_range(0, mx), 0, 0);
    for (int i = 0; i < np; i++)
      for (int j = 0; j < nr; j++)
        send_item(brrc_pkg::KindLoad, i, j, $urandom_range(0, mx),
                  $urandom_range(0, mx), 0);
    for (int k = 0; k < reqs; k++) begin
      int p, elems;
      p = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(0, np ? np - 1 : 0);
      elems = $urandom_range(0, nr);
      for (int j = 0; j < elems; j++)
        send_item(brrc_pkg::KindRequest, $urandom_range(0, 7), j,
                  $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 8),
                  $urandom_range(0, 65535), 0);
      if ($urandom_range(0, 7) == 0)
        send_item(brrc_pkg::KindUnused, $urandom_range(0, 7), $urandom_range(0, 7),
                  $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 1));
      send_item(brrc_pkg::KindRequest, p, $urandom_range(0, 7), $urandom_range(0, 4),
                $urandom_range(0, 65535), 1);
    end
  endtask

  task automatic test_reset_defaults();
    // procs_in_use is 0 after reset: every check is a bad process
    send_item(brrc_pkg::KindRequest, 0, 0, 0, 0, 1);
    send_item(brrc_pkg::KindRequest, 7, 7, 16'hFFFF, 16'hFFFF, 1);
    drain();
  endtask

  task automatic test_directed();
    set_reg(brrc_pkg::CfgProcs, 2);
    set_reg(brrc_pkg::CfgRes, 0);
    send_item(brrc_pkg::KindRequest, 1, 0, 5, 0, 1);          // no resources: granted
    send_item(brrc_pkg::KindRequest, 2, 0, 0, 0, 1);          // bad process
    drain();
    set_reg(brrc_pkg::CfgRes, 15);                           // oversized acts as eight
    set_reg(brrc_pkg::CfgProcs, 15);
    for (int j = 0; j < 8; j++) send_item(brrc_pkg::KindAvail, 0, j, 16'hFFFF, 0, 0);
    send_item(brrc_pkg::KindLoad, 0, 0, 3, 10, 0);           // claim below allocation
    send_item(brrc_pkg::KindLoad, 7, 7, 16'hFFFF, 16'hFFFF, 0);
    send_item(brrc_pkg::KindUnused, 7, 7, 16'hFFFF, 16'hFFFF, 1);  // unused kind
    send_item(brrc_pkg::KindRequest, 0, 0, 1, 0, 1);          // exceeds need
    send_item(brrc_pkg::KindLoad, 1, 0, 16'hFFFF, 0, 0);
    send_item(brrc_pkg::KindRequest, 1, 0, 16'hFFFF, 0, 1);   // granted, avail drops to zero
    send_item(brrc_pkg::KindRequest, 1, 0, 1, 0, 1);          // exceeds need
    send_item(brrc_pkg::KindAvail, 0, 1, 0, 0, 0);
    send_item(brrc_pkg::KindLoad, 2, 1, 5, 0, 0);
    send_item(brrc_pkg::KindRequest, 3, 1, 0, 0, 1);          // unsafe, rolled back
    drain();
  endtask

  task automatic test_random();
    for (int s = 0; s < 4; s++) begin
      int np, nr;
      np = (s == 0) ? 8 : (s == 1) ? 1 : $urandom_range(0, 8);
      nr = (s == 0) ? 8 : (s == 1) ? 1 : $urandom_range(1, 8);
      set_reg(brrc_pkg::CfgProcs, np);
      set_reg(brrc_pkg::CfgRes, nr);
      random_scenario(np > 3 ? 3 : np, nr > 3 ? 3 : nr, 5);
      drain();
    end
  endtask

  initial begin
    n_procs = 0; n_res = 1;
    foreach (avail[j]) begin
      avail[j] = 0; req_buf[j] = 0;
    end
    foreach (alloc_tab[i, j]) begin
      alloc_tab[i][j] = 0; need_tab[i][j] = 0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed();
    test_random();
    if (mismatches == 0 && !timed_out) begin
      $display("[bankers_resource_request_check_core] OK");
    end else begin
      $display("[bankers_resource_request_check_core] ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    timed_out = 1'b1;
    $display("[bankers_resource_request_check_core] ERROR");
    $finish;
  end
endmodule
